[rtl/differential_drive_mode_controller_defines.svh]
// Assertion macros for the drive controller RTL.
`ifndef DIFFERENTIAL_DRIVE_MODE_CONTROLLER_DEFINES_SVH
`define DIFFERENTIAL_DRIVE_MODE_CONTROLLER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Clocked check, disabled while reset is asserted.
`define DDMC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also holds during reset.
`define DDMC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DDMC_ASSERT(lbl, clk, rst_n, prop, msg)
`define DDMC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

[rtl/ddmc_pkg.sv]
// Types, constants and lookup functions for the drive mode controller.
package ddmc_pkg;

	typedef enum logic [1:0] {
		MODE_JOY  = 2'd0,
		MODE_LINE = 2'd1,
		MODE_OBST = 2'd2
	} drive_mode_t;

	typedef enum logic [1:0] {
		TURN_FWD   = 2'd0,
		TURN_LEFT  = 2'd1,
		TURN_RIGHT = 2'd2
	} line_turn_t;

	// Joystick direction codes (index into the letter list U L D R W X Y Z)
	localparam logic [2:0] DIR_U = 3'd0;
	localparam logic [2:0] DIR_L = 3'd1;
	localparam logic [2:0] DIR_D = 3'd2;
	localparam logic [2:0] DIR_R = 3'd3;
	localparam logic [2:0] DIR_W = 3'd4;
	localparam logic [2:0] DIR_X = 3'd5;
	localparam logic [2:0] DIR_Y = 3'd6;
	localparam logic [2:0] DIR_Z = 3'd7;

	// Command characters
	localparam logic [7:0] CH_A    = 8'h41;
	localparam logic [7:0] CH_B    = 8'h42;
	localparam logic [7:0] CH_C    = 8'h43;
	localparam logic [7:0] CH_U    = 8'h55;
	localparam logic [7:0] CH_L    = 8'h4C;
	localparam logic [7:0] CH_D    = 8'h44;
	localparam logic [7:0] CH_R    = 8'h52;
	localparam logic [7:0] CH_W    = 8'h57;
	localparam logic [7:0] CH_X    = 8'h58;
	localparam logic [7:0] CH_Y    = 8'h59;
	localparam logic [7:0] CH_Z    = 8'h5A;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_FIVE = 8'h35;

	localparam logic [2:0] LEVEL_MAX = 3'd5;

	// Fixed speeds used when the line is lost
	localparam logic signed [8:0] LOST_SLOW = 9'sd50;
	localparam logic signed [8:0] LOST_FAST = 9'sd100;

	// Configuration register indexes and reset values
	localparam logic REG_TURN_OFFSET = 1'b0;
	localparam logic REG_CLEAR_DIST  = 1'b1;
	localparam logic [7:0] TURN_OFFSET_RST = 8'd50;
	localparam logic [8:0] CLEAR_DIST_RST  = 9'd40;

	typedef struct packed {
		drive_mode_t mode;
		logic [2:0]  dir;
		logic [2:0]  level;
	} cmd_state_t;

	typedef struct packed {
		logic              valid;
		logic signed [8:0] left;
		logic signed [8:0] right;
	} drive_result_t;

	function automatic logic [7:0] pwm_lookup(input logic [2:0] level);
		logic [7:0] pwm;
		case (level)
			3'd0:    pwm = 8'd0;
			3'd1:    pwm = 8'd120;
			3'd2:    pwm = 8'd154;
			3'd3:    pwm = 8'd187;
			3'd4:    pwm = 8'd221;
			3'd5:    pwm = 8'd255;
			default: pwm = 8'd0;
		endcase
		return pwm;
	endfunction

endpackage

[rtl/ddmc_cmd_decode.sv]
// Command byte decoder: mode, joystick direction and speed level state.
module ddmc_cmd_decode
	import ddmc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_en,
	input  logic [7:0] rx_byte,
	output cmd_state_t cmd_state
);

	drive_mode_t mode_q;
	logic [2:0]  dir_q;
	logic [2:0]  level_q;
	logic        expect_q;

	logic        is_mode;
	drive_mode_t mode_sel;
	logic        is_dir;
	logic [2:0]  dir_sel;
	logic        is_digit;

	always_comb begin
		is_mode  = 1'b1;
		mode_sel = MODE_JOY;
		case (rx_byte)
			CH_A:    mode_sel = MODE_JOY;
			CH_B:    mode_sel = MODE_LINE;
			CH_C:    mode_sel = MODE_OBST;
			default: is_mode  = 1'b0;
		endcase

		is_dir  = 1'b1;
		dir_sel = DIR_U;
		case (rx_byte)
			CH_U:    dir_sel = DIR_U;
			CH_L:    dir_sel = DIR_L;
			CH_D:    dir_sel = DIR_D;
			CH_R:    dir_sel = DIR_R;
			CH_W:    dir_sel = DIR_W;
			CH_X:    dir_sel = DIR_X;
			CH_Y:    dir_sel = DIR_Y;
			CH_Z:    dir_sel = DIR_Z;
			default: is_dir  = 1'b0;
		endcase

		is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_FIVE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_JOY;
			dir_q    <= DIR_U;
			level_q  <= 3'd0;
			expect_q <= 1'b0;
		end else if (cmd_en) begin
			if (expect_q) begin
				// speed slot: always consumed, digits 0..5 only
				expect_q <= 1'b0;
				if (is_digit) begin
					level_q <= 3'(rx_byte - CH_ZERO);
				end
			end else if (is_mode) begin
				mode_q   <= mode_sel;
				expect_q <= 1'b1;
			end else if (is_dir) begin
				dir_q    <= dir_sel;
				expect_q <= 1'b1;
			end
		end
	end

	assign cmd_state = '{mode: mode_q, dir: dir_q, level: level_q};

endmodule

[rtl/ddmc_drive_mix.sv]
// Drive mixer: per-mode wheel speeds plus line and obstacle steering state.
module ddmc_drive_mix
	import ddmc_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          tick_en,
	input  cmd_state_t    cmd_state,
	input  logic          line_left,
	input  logic          line_right,
	input  logic [8:0]    distance_cm,
	input  logic          random_bit,
	input  logic [7:0]    turn_offset,
	input  logic [8:0]    clear_distance,
	output drive_result_t result
);

	line_turn_t last_turn_q;
	logic       armed_q;
	logic       side_q;

	logic [7:0]        sp;
	logic [7:0]        dif;
	logic signed [8:0] sp_p;
	logic signed [8:0] sp_n;
	logic signed [8:0] dif_p;
	logic signed [8:0] dif_n;
	logic              side_now;
	logic              path_clear;
	line_turn_t        turn_next;

	always_comb begin
		sp    = pwm_lookup(cmd_state.level);
		dif   = (sp >= turn_offset) ? (sp - turn_offset) : 8'd0;
		sp_p  = signed'({1'b0, sp});
		sp_n  = -sp_p;
		dif_p = signed'({1'b0, dif});
		dif_n = -dif_p;

		side_now   = armed_q ? random_bit : side_q;
		path_clear = distance_cm > clear_distance;
		turn_next  = last_turn_q;

		result = '{valid: 1'b1, left: sp_p, right: sp_p};
		case (cmd_state.mode)
			MODE_JOY: begin
				case (cmd_state.dir)
					DIR_U:   result = '{valid: 1'b1, left: sp_p,  right: sp_p};
					DIR_L:   result = '{valid: 1'b1, left: sp_n,  right: sp_p};
					DIR_D:   result = '{valid: 1'b1, left: sp_n,  right: sp_n};
					DIR_R:   result = '{valid: 1'b1, left: sp_p,  right: sp_n};
					DIR_W:   result = '{valid: 1'b1, left: dif_n, right: sp_n};
					DIR_X:   result = '{valid: 1'b1, left: dif_p, right: sp_p};
					DIR_Y:   result = '{valid: 1'b1, left: sp_p,  right: dif_p};
					default: result = '{valid: 1'b1, left: sp_n,  right: dif_n};
				endcase
			end
			MODE_LINE: begin
				case ({line_left, line_right})
					2'b00: begin
						turn_next = TURN_FWD;
						result    = '{valid: 1'b1, left: sp_p, right: sp_p};
					end
					2'b10: begin
						turn_next = TURN_LEFT;
						result    = '{valid: 1'b1, left: sp_n, right: sp_p};
					end
					2'b01: begin
						turn_next = TURN_RIGHT;
						result    = '{valid: 1'b1, left: sp_p, right: sp_n};
					end
					default: begin
						// line lost: replay the last turn, or stay silent
						case (last_turn_q)
							TURN_LEFT:  result = '{valid: 1'b1, left: LOST_SLOW,
								right: LOST_FAST};
							TURN_RIGHT: result = '{valid: 1'b1, left: LOST_FAST,
								right: LOST_SLOW};
							default:    result = '{valid: 1'b0, left: sp_p, right: sp_p};
						endcase
					end
				endcase
			end
			MODE_OBST: begin
				if (path_clear) begin
					result = '{valid: 1'b1, left: sp_p, right: sp_p};
				end else if (!side_now) begin
					result = '{valid: 1'b1, left: sp_n, right: sp_p};
				end else begin
					result = '{valid: 1'b1, left: sp_p, right: sp_n};
				end
			end
			default: result = '{valid: 1'b0, left: sp_p, right: sp_p};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_turn_q <= TURN_FWD;
			armed_q     <= 1'b1;
			side_q      <= 1'b0;
		end else if (tick_en) begin
			if (cmd_state.mode == MODE_LINE) begin
				last_turn_q <= turn_next;
			end
			if (cmd_state.mode == MODE_OBST) begin
				side_q  <= side_now;
				armed_q <= path_clear;
			end
		end
	end

endmodule

[rtl/differential_drive_mode_controller.sv]
// Pipeline: an input transaction is held in the input register; a drive tick's result
//   is then loaded into the result register, which drives the master side.
// Throughput: one input transaction per cycle unless a tick with a result meets a full result register;
//   the input and result registers decouple the sides, so a waiting result does not block a command byte behind it.
// Reset: arst_n clears all control state at once: joystick mode, forward, speed level zero,
//   turn_offset 50, clear_distance 40, obstacle side choice armed.
`include "differential_drive_mode_controller_defines.svh"

module differential_drive_mode_controller
	import ddmc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_wen,
	input  logic        cfg_index,
	input  logic [8:0]  cfg_data,
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [7:0] rx_byte, [8] line_left, [9] line_right, [18:10] distance_cm,
	// [19] random_bit, [23:20] zero
	input  logic [23:0] s_axis_tdata,
	// [0] op (0 = command byte, 1 = drive tick)
	input  logic        s_axis_tuser,
	// result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [8:0] left_speed, [17:9] right_speed, [23:18] zero
	output logic [23:0] m_axis_tdata
);

	// Configuration registers
	logic [7:0] turn_offset_q;
	logic [8:0] clear_distance_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			turn_offset_q    <= TURN_OFFSET_RST;
			clear_distance_q <= CLEAR_DIST_RST;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_TURN_OFFSET: turn_offset_q    <= cfg_data[7:0];
				REG_CLEAR_DIST:  clear_distance_q <= cfg_data;
				default:         ;
			endcase
		end
	end

	// Input register stage. The item is decoded and its state effect applied
	// only when it leaves this stage, so state changes stay in input order.
	logic       valid_s1;
	logic       op_s1;
	logic [7:0] rx_byte_s1;
	logic       line_left_s1;
	logic       line_right_s1;
	logic [8:0] distance_s1;
	logic       random_s1;

	logic          advance;
	logic          has_result;
	cmd_state_t    cmd_state;
	drive_result_t mix_result;

	// Output register
	logic              out_valid_q;
	logic signed [8:0] left_q;
	logic signed [8:0] right_q;

	// A tick that yields a result needs room in the output register; a command
	// byte or a silent tick leaves immediately.
	assign has_result    = op_s1 && mix_result.valid;
	assign advance       = valid_s1 && (!has_result || !out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			op_s1         <= s_axis_tuser;
			rx_byte_s1    <= s_axis_tdata[7:0];
			line_left_s1  <= s_axis_tdata[8];
			line_right_s1 <= s_axis_tdata[9];
			distance_s1   <= s_axis_tdata[18:10];
			random_s1     <= s_axis_tdata[19];
		end
	end

	ddmc_cmd_decode u_cmd_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_en    (advance && !op_s1),
		.rx_byte   (rx_byte_s1),
		.cmd_state (cmd_state)
	);

	ddmc_drive_mix u_drive_mix (
		.clk            (clk),
		.arst_n         (arst_n),
		.tick_en        (advance && op_s1),
		.cmd_state      (cmd_state),
		.line_left      (line_left_s1),
		.line_right     (line_right_s1),
		.distance_cm    (distance_s1),
		.random_bit     (random_s1),
		.turn_offset    (turn_offset_q),
		.clear_distance (clear_distance_q),
		.result         (mix_result)
	);

	// Load a new result when the stage hands one over; drop the valid once
	// the downstream side has taken the transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && has_result) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_result) begin
			left_q  <= mix_result.left;
			right_q <= mix_result.right;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'd0, right_q, left_q};

	// Checks on the internal flow
	`DDMC_ASSERT(a_result_loads, clk, arst_n, (advance && has_result) |=> out_valid_q, "result lost at output register")
	`DDMC_ASSERT(a_empty_stage_ready, clk, arst_n, !valid_s1 |-> s_axis_tready, "empty input stage refuses data")
	`DDMC_ASSERT(a_level_range, clk, arst_n, cmd_state.level <= LEVEL_MAX, "speed level out of range")
	`DDMC_ASSERT(a_cmd_no_result, clk, arst_n, (valid_s1 && !op_s1) |-> advance, "command byte stalled")

endmodule

[sim/tb_top.sv]
// Self-checking testbench for the differential drive mode controller.
`timescale 1ns / 1ps

module tb_top;
	import ddmc_pkg::*;

	localparam bit OP_CMD  = 1'b0;
	localparam bit OP_TICK = 1'b1;

	localparam int CLK_HALF       = 5;
	localparam int RESET_CYCLES   = 9;
	localparam int SETTLE_CYCLES  = 4;     // pipeline depth plus margin
	localparam int HOLD_CYCLES    = 300;   // long output hold-off to back up the input
	localparam int QUIET_LIMIT    = 2000;  // cycles with no transaction before giving up
	localparam int IDLE_PERCENT   = 30;
	localparam int PHASES         = 6;
	localparam int ITEMS_PER_PHASE = 155;
	localparam int REPORT_CAP     = 200;

	localparam int PWM_STEPS [0:5] = '{0, 120, 154, 187, 221, 255};

	// One input transaction, split into its fields.
	typedef struct packed {
		logic       op;
		logic [7:0] rx;
		logic       ll;
		logic       lr;
		logic [8:0] dist_cm;
		logic       rnd;
	} drive_item_t;

	typedef struct packed {
		logic signed [8:0] left;
		logic signed [8:0] right;
	} speed_pair_t;

	// How a directed row is checked: by the predictor, against a typed pair, or as silent.
	typedef enum logic [1:0] {
		CHK_MODEL,
		CHK_FIXED,
		CHK_SILENT
	} row_check_t;

	typedef struct {
		drive_item_t item;
		row_check_t  chk;
		int          left;
		int          right;
	} speed_row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_wen;
	logic        cfg_index;
	logic [8:0]  cfg_data;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata;
	logic        s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [23:0] m_axis_tdata;

	differential_drive_mode_controller dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wen       (cfg_wen),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// Predictor state: a private copy of the controller's registers.
	drive_mode_t mdl_mode;
	logic [2:0]  mdl_dir;
	logic [2:0]  mdl_level;
	bit          mdl_want_level;
	line_turn_t  mdl_last_turn;
	bit          mdl_armed;
	bit          mdl_side;
	logic [7:0]  mdl_turn_offset;
	logic [8:0]  mdl_clear_dist;

	// Speed pairs predicted but not yet seen on the result stream, oldest first.
	speed_pair_t pending_speeds[$];
	speed_row_t  directed_rows[$];

	int  mismatch_count;
	int  speeds_checked;
	int  cmd_count;
	int  tick_count;
	int  ticks_in_mode [0:2];
	int  settings_count;
	bit  steady;          // no idling on either side while set
	bit  hold_request;    // ask the result side for a long hold-off
	int  hold_left;

	initial begin : clock_gen
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	function automatic bit roll_idle();
		return !steady && ($urandom_range(0, 99) < IDLE_PERCENT);
	endfunction

	function automatic speed_pair_t pair(input int l, input int r);
		speed_pair_t p;
		p.left  = 9'(l);
		p.right = 9'(r);
		return p;
	endfunction

	function automatic drive_item_t byte_item(input logic [7:0] b);
		drive_item_t it;
		it         = '0;
		it.op      = OP_CMD;
		it.rx      = b;
		it.dist_cm = 9'($urandom);
		it.ll      = 1'($urandom);
		it.lr      = 1'($urandom);
		it.rnd     = 1'($urandom);
		return it;
	endfunction

	function automatic drive_item_t tick_item(input bit ll, input bit lr, input int dist_cm,
			input bit rnd);
		drive_item_t it;
		it.op      = OP_TICK;
		it.rx      = 8'($urandom);
		it.ll      = ll;
		it.lr      = lr;
		it.dist_cm = 9'(dist_cm);
		it.rnd     = rnd;
		return it;
	endfunction

	function automatic void add_row(input drive_item_t it, input row_check_t chk,
			input int l = 0, input int r = 0);
		speed_row_t row;
		row.item  = it;
		row.chk   = chk;
		row.left  = l;
		row.right = r;
		directed_rows.push_back(row);
	endfunction

	// Advance the predictor by one accepted transaction; report the speeds it drives, if any.
	task automatic step_drive_model(input drive_item_t it, output bit has_speed,
			output speed_pair_t speeds);
		int pwm;
		int inner;
		has_speed = 1'b0;
		speeds    = '0;
		if (it.op == OP_CMD) begin
			cmd_count++;
			if (mdl_want_level) begin
				// the slot after a letter swallows the byte; only '0'..'5' change the level
				mdl_want_level = 1'b0;
				if (it.rx >= CH_ZERO && it.rx <= CH_FIVE)
					mdl_level = 3'(it.rx - CH_ZERO);
			end else begin
				mdl_want_level = 1'b1;
				case (it.rx)
					CH_A: mdl_mode = MODE_JOY;
					CH_B: mdl_mode = MODE_LINE;
					CH_C: mdl_mode = MODE_OBST;
					CH_U: mdl_dir = DIR_U;
					CH_L: mdl_dir = DIR_L;
					CH_D: mdl_dir = DIR_D;
					CH_R: mdl_dir = DIR_R;
					CH_W: mdl_dir = DIR_W;
					CH_X: mdl_dir = DIR_X;
					CH_Y: mdl_dir = DIR_Y;
					CH_Z: mdl_dir = DIR_Z;
					default: mdl_want_level = 1'b0;
				endcase
			end
		end else begin
			tick_count++;
			ticks_in_mode[mdl_mode]++;
			pwm   = (mdl_level <= LEVEL_MAX) ? PWM_STEPS[mdl_level] : 0;
			inner = (pwm >= int'(mdl_turn_offset)) ? pwm - int'(mdl_turn_offset) : 0;
			has_speed = 1'b1;
			case (mdl_mode)
				MODE_JOY: begin
					case (mdl_dir)
						DIR_U:   speeds = pair(pwm, pwm);
						DIR_L:   speeds = pair(-pwm, pwm);
						DIR_D:   speeds = pair(-pwm, -pwm);
						DIR_R:   speeds = pair(pwm, -pwm);
						DIR_W:   speeds = pair(-inner, -pwm);
						DIR_X:   speeds = pair(inner, pwm);
						DIR_Y:   speeds = pair(pwm, inner);
						default: speeds = pair(-pwm, -inner);
					endcase
				end
				MODE_LINE: begin
					if (!it.ll && !it.lr) begin
						mdl_last_turn = TURN_FWD;
						speeds = pair(pwm, pwm);
					end else if (it.ll && !it.lr) begin
						mdl_last_turn = TURN_LEFT;
						speeds = pair(-pwm, pwm);
					end else if (!it.ll && it.lr) begin
						mdl_last_turn = TURN_RIGHT;
						speeds = pair(pwm, -pwm);
					end else if (mdl_last_turn == TURN_LEFT) begin
						speeds = pair(LOST_SLOW, LOST_FAST);
					end else if (mdl_last_turn == TURN_RIGHT) begin
						speeds = pair(LOST_FAST, LOST_SLOW);
					end else begin
						// line lost with no turn remembered: motors untouched
						has_speed = 1'b0;
					end
				end
				MODE_OBST: begin
					if (mdl_armed)
						mdl_side = it.rnd;
					if (it.dist_cm > mdl_clear_dist) begin
						mdl_armed = 1'b1;
						speeds = pair(pwm, pwm);
					end else begin
						mdl_armed = 1'b0;
						speeds = mdl_side ? pair(pwm, -pwm) : pair(-pwm, pwm);
					end
				end
				default: has_speed = 1'b0;
			endcase
		end
	endtask

	// Offer one transaction, hold it until accepted, then predict its outcome.
	// Ready is sampled at the falling edge so the handshake never races the rising edge.
	task automatic send_item(input drive_item_t it, input row_check_t chk = CHK_MODEL,
			input int fixed_l = 0, input int fixed_r = 0);
		bit          ready_seen;
		bit          has_speed;
		speed_pair_t speeds;
		while (roll_idle()) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= it.op;
		s_axis_tdata  <= {4'b0, it.rnd, it.dist_cm, it.lr, it.ll, it.rx};
		do begin
			@(negedge clk);
			ready_seen = s_axis_tready;
			@(posedge clk);
		end while (!ready_seen);
		step_drive_model(it, has_speed, speeds);
		case (chk)
			CHK_FIXED:  pending_speeds.push_back(pair(fixed_l, fixed_r));
			CHK_SILENT: ;
			default:    if (has_speed) pending_speeds.push_back(speeds);
		endcase
	endtask

	// Drop valid and wait until every predicted result is out, plus the pipeline depth.
	task automatic wait_quiet();
		s_axis_tvalid <= 1'b0;
		while (pending_speeds.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write both registers back to back; lower the enable once at the end.
	task automatic write_settings(input int offset, input int clear_dist);
		cfg_wen   <= 1'b1;
		cfg_index <= REG_TURN_OFFSET;
		cfg_data  <= 9'(offset);
		@(posedge clk);
		mdl_turn_offset = 8'(offset);
		cfg_index <= REG_CLEAR_DIST;
		cfg_data  <= 9'(clear_dist);
		@(posedge clk);
		mdl_clear_dist = 9'(clear_dist);
		cfg_wen <= 1'b0;
		settings_count++;
	endtask

	function automatic logic [7:0] random_letter();
		case ($urandom_range(0, 10))
			0:       return CH_A;
			1:       return CH_B;
			2:       return CH_C;
			3:       return CH_U;
			4:       return CH_L;
			5:       return CH_D;
			6:       return CH_R;
			7:       return CH_W;
			8:       return CH_X;
			9:       return CH_Y;
			default: return CH_Z;
		endcase
	endfunction

	// Distances cluster around the clear threshold, with some spread over the full range.
	function automatic drive_item_t random_tick();
		int d;
		case ($urandom_range(0, 2))
			0:       d = int'($urandom_range(0, 511));
			1:       d = int'(mdl_clear_dist) + int'($urandom_range(0, 2)) - 1;
			default: d = int'($urandom_range(0, 60));
		endcase
		if (d < 0)
			d = 0;
		if (d > 511)
			d = 511;
		return tick_item(1'($urandom), 1'($urandom), d, 1'($urandom));
	endfunction

	// Mostly well-formed letter+digit pairs and ticks; the rest is stray or broken bytes.
	// Returns how many transactions count toward the phase budget.
	task automatic send_random_burst(output int counted);
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 55) begin
			send_item(random_tick());
			counted = 1;
		end else if (pick < 88) begin
			send_item(byte_item(random_letter()));
			send_item(byte_item(8'(CH_ZERO + $urandom_range(0, LEVEL_MAX))));
			counted = 2;
		end else if (pick < 94) begin
			// letter followed by a byte that is not a valid level
			send_item(byte_item(random_letter()));
			send_item(byte_item(8'($urandom)));
			counted = 2;
		end else begin
			// stray byte; mostly ignored, so it does not count
			send_item(byte_item(8'($urandom)));
			counted = 0;
		end
	endtask

	// Compare one accepted result against the oldest prediction.
	task automatic check_speeds(input logic [23:0] word);
		logic signed [8:0] got_l;
		logic signed [8:0] got_r;
		speed_pair_t       want;
		got_l = word[8:0];
		got_r = word[17:9];
		speeds_checked++;
		if (pending_speeds.size() == 0) begin
			mismatch_count++;
			if (mismatch_count <= REPORT_CAP)
				$display("%0t: unexpected result, expected none, actual left %0d right %0d",
					$time, got_l, got_r);
		end else begin
			want = pending_speeds.pop_front();
			if (got_l !== want.left) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_CAP)
					$display("%0t: left_speed expected %0d actual %0d",
						$time, want.left, got_l);
			end
			if (got_r !== want.right) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_CAP)
					$display("%0t: right_speed expected %0d actual %0d",
						$time, want.right, got_r);
			end
		end
	endtask

	// Result side: sample at the falling edge, act at the rising edge, then pick the
	// next ready. A hold-off request is counted out here, down by one on each loop.
	initial begin : speed_sink
		bit          took;
		logic [23:0] word;
		m_axis_tready <= 1'b0;
		forever begin
			@(negedge clk);
			took = m_axis_tvalid && m_axis_tready;
			word = m_axis_tdata;
			@(posedge clk);
			if (took)
				check_speeds(word);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= !roll_idle();
			end
		end
	end

	// Give up when neither side moves a transaction for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(negedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Timeout after %0d cycles with no transaction", QUIET_LIMIT);
		$display("Mismatches found");
		$finish;
	end

	initial begin : stimulus
		int phase_offset [0:PHASES-1];
		int phase_clear [0:PHASES-1];
		int sent;
		int counted;

		// Hold every input at a known value from time zero.
		arst_n        <= 1'b0;
		cfg_wen       <= 1'b0;
		cfg_index     <= REG_TURN_OFFSET;
		cfg_data      <= '0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= OP_CMD;

		mismatch_count = 0;
		speeds_checked = 0;
		cmd_count      = 0;
		tick_count     = 0;
		ticks_in_mode  = '{0, 0, 0};
		settings_count = 0;
		steady         = 1'b0;
		hold_request   = 1'b0;
		hold_left      = 0;

		mdl_mode        = MODE_JOY;
		mdl_dir         = DIR_U;
		mdl_level       = '0;
		mdl_want_level  = 1'b0;
		mdl_last_turn   = TURN_FWD;
		mdl_armed       = 1'b1;
		mdl_side        = 1'b0;
		mdl_turn_offset = TURN_OFFSET_RST;
		mdl_clear_dist  = CLEAR_DIST_RST;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, at reset settings (offset 50, clear distance 40).
		add_row(tick_item(0, 0, 0, 0), CHK_FIXED, 0, 0);        // reset: forward, level zero
		add_row(byte_item(CH_U), CHK_MODEL);
		add_row(byte_item(CH_FIVE), CHK_MODEL);
		add_row(tick_item(0, 0, 0, 0), CHK_FIXED, 255, 255);    // top speed forward
		add_row(byte_item(CH_Z), CHK_MODEL);
		add_row(byte_item(8'h39), CHK_MODEL);                    // digit above five: no change
		add_row(tick_item(1, 1, 511, 1), CHK_FIXED, -255, -205);
		add_row(byte_item(CH_W), CHK_MODEL);
		add_row(byte_item(CH_A), CHK_MODEL);                     // letter in the level slot
		add_row(byte_item(8'hFF), CHK_MODEL);                    // unknown byte, ignored
		add_row(tick_item(0, 1, 0, 0), CHK_FIXED, -205, -255);
		add_row(byte_item(CH_Y), CHK_MODEL);
		add_row(byte_item(CH_ZERO), CHK_MODEL);
		add_row(tick_item(0, 0, 0, 0), CHK_FIXED, 0, 0);        // diagonal below offset
		add_row(byte_item(CH_B), CHK_MODEL);
		add_row(byte_item(8'h33), CHK_MODEL);
		add_row(tick_item(1, 1, 0, 0), CHK_SILENT);             // line lost after forward
		add_row(tick_item(1, 0, 0, 0), CHK_MODEL);
		add_row(tick_item(1, 1, 0, 0), CHK_FIXED, 50, 100);     // line lost after left
		add_row(tick_item(0, 1, 0, 0), CHK_MODEL);
		add_row(tick_item(1, 1, 0, 0), CHK_FIXED, 100, 50);     // line lost after right
		add_row(byte_item(CH_C), CHK_MODEL);
		add_row(byte_item(8'h00), CHK_MODEL);
		add_row(tick_item(0, 0, 511, 1), CHK_MODEL);            // clear path, arms the choice
		add_row(tick_item(0, 0, 0, 1), CHK_MODEL);              // blocked, samples the side
		add_row(tick_item(0, 0, 0, 0), CHK_MODEL);              // blocked, side stays latched
		foreach (directed_rows[i])
			send_item(directed_rows[i].item, directed_rows[i].chk,
				directed_rows[i].left, directed_rows[i].right);

		// Random part: one register setting per phase, extremes first.
		phase_offset = '{0, 255, 154, 0, 0, TURN_OFFSET_RST};
		phase_clear  = '{0, 511, 200, 0, 0, CLEAR_DIST_RST};
		phase_offset[3] = $urandom_range(0, 255);
		phase_clear[3]  = $urandom_range(0, 511);
		phase_offset[4] = $urandom_range(0, 255);
		phase_clear[4]  = $urandom_range(0, 511);

		for (int ph = 0; ph < PHASES; ph++) begin
			wait_quiet();
			write_settings(phase_offset[ph], phase_clear[ph]);
			steady = (ph == 3);
			if (ph == 1) begin
				// Start in joystick mode at full speed so every tick backs up the output.
				send_item(byte_item(CH_A));
				send_item(byte_item(CH_FIVE));
				hold_request = 1'b1;
			end
			sent = 0;
			while (sent < ITEMS_PER_PHASE) begin
				send_random_burst(counted);
				sent += counted;
			end
		end
		steady = 1'b0;

		wait_quiet();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Covered %0d command bytes and %0d drive ticks (joystick %0d, line %0d, %s %0d)",
			cmd_count, tick_count, ticks_in_mode[MODE_JOY], ticks_in_mode[MODE_LINE],
			"obstacle", ticks_in_mode[MODE_OBST]);
		$display("over %0d register settings, with %0d speed results checked.",
			settings_count, speeds_checked);
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
